### rtl/sst_pkg.sv
`timescale 1ns / 1ps
// shared types, codes, keyword table and character classes for the source tokenizer
package sst_pkg;

   localparam int COUNTER_BITS_DEFAULT = 24;
   localparam int FIELD_BITS = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int KW_COUNT = 14;
   localparam logic [3:0] IDENT_LEN_MAX = 4'd15;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END = 1'b1;

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_LINEC, M_BLOCKC, M_BLOCKSTAR, M_NUMBER, M_IDENT,
      M_STRING, M_OPEQ, M_OPBANG, M_OPGT, M_OPLT, M_OPAMP, M_OPBAR, M_ERROR
   } lexer_mode_type;

   localparam logic [5:0] K_NUMBER = 6'd0;
   localparam logic [5:0] K_IDENT = 6'd15;
   localparam logic [5:0] K_STRING = 6'd16;
   localparam logic [5:0] K_PLUS = 6'd17;
   localparam logic [5:0] K_MINUS = 6'd18;
   localparam logic [5:0] K_STAR = 6'd19;
   localparam logic [5:0] K_SLASH = 6'd20;
   localparam logic [5:0] K_PERCENT = 6'd21;
   localparam logic [5:0] K_EQ = 6'd22;
   localparam logic [5:0] K_EQEQ = 6'd23;
   localparam logic [5:0] K_NOT = 6'd24;
   localparam logic [5:0] K_NE = 6'd25;
   localparam logic [5:0] K_GT = 6'd26;
   localparam logic [5:0] K_GE = 6'd27;
   localparam logic [5:0] K_LT = 6'd28;
   localparam logic [5:0] K_LE = 6'd29;
   localparam logic [5:0] K_AND = 6'd30;
   localparam logic [5:0] K_OR = 6'd31;
   localparam logic [5:0] K_SEMI = 6'd32;
   localparam logic [5:0] K_LPAREN = 6'd33;
   localparam logic [5:0] K_RPAREN = 6'd34;
   localparam logic [5:0] K_LBRACE = 6'd35;
   localparam logic [5:0] K_RBRACE = 6'd36;
   localparam logic [5:0] K_LBRACKET = 6'd37;
   localparam logic [5:0] K_RBRACKET = 6'd38;
   localparam logic [5:0] K_COMMA = 6'd39;
   localparam logic [5:0] K_EOF = 6'd40;

   localparam logic [2:0] E_NONE = 3'd0;
   localparam logic [2:0] E_STRING = 3'd1;
   localparam logic [2:0] E_AMP = 3'd2;
   localparam logic [2:0] E_BAR = 3'd3;
   localparam logic [2:0] E_CHAR = 3'd4;

   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_UNDERSCORE = "_";

   // keyword text, right aligned, first character in the highest used byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "entier", "texte", "booleen", "liste", "si", "sinon", "tantque",
      "pour", "allant", "de", "a", "dans", "afficher", "fonction"
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd6, 4'd5, 4'd7, 4'd5, 4'd2, 4'd5, 4'd7,
      4'd4, 4'd6, 4'd2, 4'd1, 4'd4, 4'd8, 4'd8
   };

   typedef struct packed {
      logic [5:0]            token_kind;
      logic [2:0]            error_code;
      logic [FIELD_BITS-1:0] line_number;
      logic [FIELD_BITS-1:0] text_offset;
      logic [FIELD_BITS-1:0] text_length;
      logic [7:0]            error_char;
   } token_type;

   // results of one input byte: one or two tokens
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } item_record_type;

   typedef struct packed {
      lexer_mode_type mode;
      logic           emit;
      logic           fault;
      logic [5:0]     kind;
      logic           quote;
      logic           word;
   } start_class_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
      logic [63:0] w;
      int sh;
      w = KW_TEXT[k];
      sh = 0;
      if (pos < KW_LEN[k]) begin
         sh = (int'(KW_LEN[k]) - 1 - int'(pos)) * 8;
         return 8'(w >> sh);
      end
      return 8'd0;
   endfunction

   function automatic logic [KW_COUNT-1:0] kw_next(input logic [KW_COUNT-1:0] mask,
                                                   input logic [3:0] len,
                                                   input logic [7:0] c);
      logic [KW_COUNT-1:0] nxt;
      nxt = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (((len == 4'd0) || mask[k]) && (len < KW_LEN[k]) && (kw_char(k, len) == c)) begin
            nxt[k] = 1'b1;
         end
      end
      return nxt;
   endfunction

   function automatic logic [5:0] kw_kind(input logic [KW_COUNT-1:0] mask,
                                          input logic [3:0] len);
      logic [5:0] res;
      res = K_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (mask[k] && (KW_LEN[k] == len)) begin
            res = 6'(k + 1);
         end
      end
      return res;
   endfunction

   function automatic logic [5:0] op_single(input lexer_mode_type m);
      case (m)
         M_OPEQ: return K_EQ;
         M_OPBANG: return K_NOT;
         M_OPGT: return K_GT;
         default: return K_LT;
      endcase
   endfunction

   // what a byte does when it opens a new token
   function automatic start_class_type start_class(input logic [7:0] c);
      start_class_type s;
      s = '{mode: M_IDLE, emit: 1'b0, fault: 1'b0, kind: K_NUMBER, quote: 1'b0, word: 1'b0};
      if (is_space(c)) begin
         s.mode = M_IDLE;
      end else if (is_digit(c)) begin
         s.mode = M_NUMBER;
      end else if (is_alpha(c) || (c == CH_UNDERSCORE)) begin
         s.mode = M_IDENT;
         s.word = 1'b1;
      end else begin
         case (c)
            "\"": begin
               s.mode = M_STRING;
               s.quote = 1'b1;
            end
            "/": s.mode = M_SLASH;
            "=": s.mode = M_OPEQ;
            "!": s.mode = M_OPBANG;
            ">": s.mode = M_OPGT;
            "<": s.mode = M_OPLT;
            "&": s.mode = M_OPAMP;
            "|": s.mode = M_OPBAR;
            "+": begin s.emit = 1'b1; s.kind = K_PLUS; end
            "-": begin s.emit = 1'b1; s.kind = K_MINUS; end
            "*": begin s.emit = 1'b1; s.kind = K_STAR; end
            "%": begin s.emit = 1'b1; s.kind = K_PERCENT; end
            ";": begin s.emit = 1'b1; s.kind = K_SEMI; end
            "(": begin s.emit = 1'b1; s.kind = K_LPAREN; end
            ")": begin s.emit = 1'b1; s.kind = K_RPAREN; end
            "{": begin s.emit = 1'b1; s.kind = K_LBRACE; end
            "}": begin s.emit = 1'b1; s.kind = K_RBRACE; end
            "[": begin s.emit = 1'b1; s.kind = K_LBRACKET; end
            "]": begin s.emit = 1'b1; s.kind = K_RBRACKET; end
            ",": begin s.emit = 1'b1; s.kind = K_COMMA; end
            default: begin
               s.emit = 1'b1;
               s.fault = 1'b1;
               s.mode = M_ERROR;
            end
         endcase
      end
      return s;
   endfunction

   function automatic token_type make_tok(input logic [5:0] kind,
                                          input logic [2:0] err,
                                          input logic [FIELD_BITS-1:0] line,
                                          input logic [FIELD_BITS-1:0] off,
                                          input logic [FIELD_BITS-1:0] len,
                                          input logic [7:0] ch);
      token_type t;
      t.token_kind = kind;
      t.error_code = err;
      t.line_number = line;
      t.text_offset = off;
      t.text_length = len;
      t.error_char = ch;
      return t;
   endfunction

endpackage

### rtl/sst_req_if.sv
`timescale 1ns / 1ps
// source byte channel: valid, ready and one byte or end marker
interface sst_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] source_byte;

   modport source (output valid, output cmd, output source_byte, input ready);
   modport sink (input valid, input cmd, input source_byte, output ready);
endinterface

### rtl/sst_rsp_if.sv
`timescale 1ns / 1ps
// token channel: valid, ready and one token or error
interface sst_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [5:0]                      token_kind;
   logic [2:0]                      error_code;
   logic [sst_pkg::FIELD_BITS-1:0]  line_number;
   logic [sst_pkg::FIELD_BITS-1:0]  text_offset;
   logic [sst_pkg::FIELD_BITS-1:0]  text_length;
   logic [7:0]                      error_char;
   logic                            last_of_item;

   modport source (output valid, output token_kind, output error_code, output line_number,
                   output text_offset, output text_length, output error_char,
                   output last_of_item, input ready);
   modport sink (input valid, input token_kind, input error_code, input line_number,
                 input text_offset, input text_length, input error_char,
                 input last_of_item, output ready);
endinterface

### rtl/script_source_tokenizer.sv
`timescale 1ns / 1ps
// top level of the streaming source tokenizer: lexer, record queue and output stage
//
//   channel   dir   payload                                            transfer when
//   req_ch    in    cmd, source_byte                                   valid && ready
//   rsp_ch    out   token_kind, error_code, line_number, text_offset,  valid && ready
//                   text_length, error_char, last_of_item
//
// one input transfer per cycle while the record queue has room; each result goes
// through the record queue to the output register. a byte that ends one token and
// starts another gives two results; the four-entry record queue absorbs these bursts.
// req_ch.ready drops only while the record queue is full.
// synchronous reset clears lexer state, counters, queue pointers and output valid.
module script_source_tokenizer #(
   parameter int COUNTER_BITS = sst_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sst_req_if.sink   req_ch,
   sst_rsp_if.source rsp_ch
);

   logic                     take;
   logic                     rec_push;
   sst_pkg::item_record_type rec;
   logic                     q_full;
   logic                     q_pop;
   logic                     head_valid;
   sst_pkg::item_record_type head_rec;

   assign req_ch.ready = !q_full;
   assign take = req_ch.valid && !q_full;

   sst_front #(
      .COUNTER_BITS(COUNTER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .cmd        (req_ch.cmd),
      .source_byte(req_ch.source_byte),
      .rec_push   (rec_push),
      .rec        (rec)
   );

   sst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_rec  (rec),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(head_valid),
      .head_rec  (head_rec)
   );

   sst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_rec  (head_rec),
      .pop       (q_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

### rtl/sst_front.sv
`timescale 1ns / 1ps
// lexer front end: mode state, counters, keyword mask and per-byte token record
module sst_front #(
   parameter int COUNTER_BITS = sst_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic                     cmd,
   input  logic [7:0]               source_byte,
   output logic                     rec_push,
   output sst_pkg::item_record_type rec
);

   localparam int FB = sst_pkg::FIELD_BITS;

   sst_pkg::lexer_mode_type          mode_ff, mode_in;
   logic [COUNTER_BITS-1:0]          line_ff, line_in;
   logic [COUNTER_BITS-1:0]          offset_ff, offset_in;
   logic [COUNTER_BITS-1:0]          start_ff, start_in;
   logic [sst_pkg::KW_COUNT-1:0]     cand_ff, cand_in;
   logic [3:0]                       idlen_ff, idlen_in;

   sst_pkg::start_class_type st;
   logic [COUNTER_BITS-1:0]  len_cur;
   logic [COUNTER_BITS-1:0]  len_str;
   logic                     restart;
   logic [FB-1:0]            line_f, offset_f, start_f, len_cur_f, len_str_f;
   logic                     prim_valid, sec_valid;
   sst_pkg::token_type       prim, sec;

   function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [FB-1:0] to_field(input logic [COUNTER_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[FB-1:0];
   endfunction

   always_comb begin
      st = sst_pkg::start_class(source_byte);
      len_cur = offset_ff - start_ff;
      len_str = (offset_ff >= start_ff) ? len_cur : '0;
      line_f = to_field(line_ff);
      offset_f = to_field(offset_ff);
      start_f = to_field(start_ff);
      len_cur_f = to_field(len_cur);
      len_str_f = to_field(len_str);
      restart = 1'b0;
      if (cmd == sst_pkg::CMD_BYTE) begin
         case (mode_ff)
            sst_pkg::M_IDLE: restart = 1'b1;
            sst_pkg::M_SLASH: restart = (source_byte != "/") && (source_byte != "*");
            sst_pkg::M_NUMBER: restart = !sst_pkg::is_digit(source_byte);
            sst_pkg::M_IDENT: restart = !sst_pkg::is_word(source_byte);
            sst_pkg::M_OPEQ, sst_pkg::M_OPBANG, sst_pkg::M_OPGT, sst_pkg::M_OPLT:
               restart = (source_byte != "=");
            default: restart = 1'b0;
         endcase
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      line_in = line_ff;
      offset_in = offset_ff;
      start_in = start_ff;
      cand_in = cand_ff;
      idlen_in = idlen_ff;
      if (take) begin
         if (cmd == sst_pkg::CMD_END) begin
            mode_in = sst_pkg::M_IDLE;
            line_in = COUNTER_BITS'(1);
            offset_in = '0;
            start_in = '0;
            cand_in = '0;
            idlen_in = '0;
         end else if (mode_ff != sst_pkg::M_ERROR) begin
            case (mode_ff)
               sst_pkg::M_SLASH: begin
                  if (source_byte == "/") begin
                     mode_in = sst_pkg::M_LINEC;
                  end else if (source_byte == "*") begin
                     mode_in = sst_pkg::M_BLOCKC;
                  end
               end
               sst_pkg::M_LINEC: begin
                  if (source_byte == sst_pkg::CH_NEWLINE) begin
                     mode_in = sst_pkg::M_IDLE;
                  end
               end
               sst_pkg::M_BLOCKC: begin
                  if (source_byte == "*") begin
                     mode_in = sst_pkg::M_BLOCKSTAR;
                  end
               end
               sst_pkg::M_BLOCKSTAR: begin
                  if (source_byte == "/") begin
                     mode_in = sst_pkg::M_IDLE;
                  end else if (source_byte != "*") begin
                     mode_in = sst_pkg::M_BLOCKC;
                  end
               end
               sst_pkg::M_IDENT: begin
                  if (sst_pkg::is_word(source_byte)) begin
                     cand_in = sst_pkg::kw_next(cand_ff, idlen_ff, source_byte);
                     idlen_in = (idlen_ff == sst_pkg::IDENT_LEN_MAX) ? idlen_ff
                                                                    : idlen_ff + 4'd1;
                  end
               end
               sst_pkg::M_STRING: begin
                  if (source_byte == "\"") begin
                     mode_in = sst_pkg::M_IDLE;
                  end
               end
               sst_pkg::M_OPEQ, sst_pkg::M_OPBANG, sst_pkg::M_OPGT, sst_pkg::M_OPLT: begin
                  if (source_byte == "=") begin
                     mode_in = sst_pkg::M_IDLE;
                  end
               end
               sst_pkg::M_OPAMP: begin
                  mode_in = (source_byte == "&") ? sst_pkg::M_IDLE : sst_pkg::M_ERROR;
               end
               sst_pkg::M_OPBAR: begin
                  mode_in = (source_byte == "|") ? sst_pkg::M_IDLE : sst_pkg::M_ERROR;
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
            if (restart) begin
               mode_in = st.mode;
               start_in = st.quote ? sat_inc(offset_ff) : offset_ff;
               if (st.word) begin
                  cand_in = sst_pkg::kw_next('0, 4'd0, source_byte);
                  idlen_in = 4'd1;
               end
            end
            if (source_byte == sst_pkg::CH_NEWLINE) begin
               line_in = sat_inc(line_ff);
            end
            offset_in = sat_inc(offset_ff);
         end
      end
   end

   // token record for this byte
   always_comb begin
      prim_valid = 1'b0;
      prim = '0;
      sec_valid = 1'b0;
      sec = '0;
      if (cmd == sst_pkg::CMD_END) begin
         case (mode_ff)
            sst_pkg::M_SLASH: begin
               prim_valid = 1'b1;
               prim = sst_pkg::make_tok(sst_pkg::K_SLASH, sst_pkg::E_NONE, line_f, start_f,
                                        FB'(1), 8'd0);
            end
            sst_pkg::M_NUMBER: begin
               prim_valid = 1'b1;
               prim = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_NONE, line_f, start_f,
                                        len_cur_f, 8'd0);
            end
            sst_pkg::M_IDENT: begin
               prim_valid = 1'b1;
               prim = sst_pkg::make_tok(sst_pkg::kw_kind(cand_ff, idlen_ff), sst_pkg::E_NONE,
                                        line_f, start_f, len_cur_f, 8'd0);
            end
            sst_pkg::M_STRING: begin
               prim_valid = 1'b1;
               prim = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_STRING, line_f, start_f,
                                        '0, 8'd0);
            end
            sst_pkg::M_OPEQ, sst_pkg::M_OPBANG, sst_pkg::M_OPGT, sst_pkg::M_OPLT: begin
               prim_valid = 1'b1;
               prim = sst_pkg::make_tok(sst_pkg::op_single(mode_ff), sst_pkg::E_NONE, line_f,
                                        start_f, FB'(1), 8'd0);
            end
            sst_pkg::M_OPAMP: begin
               prim_valid = 1'b1;
               prim = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_AMP, line_f, start_f,
                                        '0, "&");
            end
            sst_pkg::M_OPBAR: begin
               prim_valid = 1'b1;
               prim = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_BAR, line_f, start_f,
                                        '0, "|");
            end
            default: prim_valid = 1'b0;
         endcase
         sec_valid = (mode_ff != sst_pkg::M_STRING) && (mode_ff != sst_pkg::M_OPAMP) &&
                     (mode_ff != sst_pkg::M_OPBAR) && (mode_ff != sst_pkg::M_ERROR);
         sec = sst_pkg::make_tok(sst_pkg::K_EOF, sst_pkg::E_NONE, line_f, offset_f, '0, 8'd0);
      end else begin
         case (mode_ff)
            sst_pkg::M_SLASH: begin
               prim_valid = restart;
               prim = sst_pkg::make_tok(sst_pkg::K_SLASH, sst_pkg::E_NONE, line_f, start_f,
                                        FB'(1), 8'd0);
            end
            sst_pkg::M_NUMBER: begin
               prim_valid = restart;
               prim = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_NONE, line_f, start_f,
                                        len_cur_f, 8'd0);
            end
            sst_pkg::M_IDENT: begin
               prim_valid = restart;
               prim = sst_pkg::make_tok(sst_pkg::kw_kind(cand_ff, idlen_ff), sst_pkg::E_NONE,
                                        line_f, start_f, len_cur_f, 8'd0);
            end
            sst_pkg::M_STRING: begin
               prim_valid = (source_byte == "\"");
               prim = sst_pkg::make_tok(sst_pkg::K_STRING, sst_pkg::E_NONE, line_f, start_f,
                                        len_str_f, 8'd0);
            end
            sst_pkg::M_OPEQ, sst_pkg::M_OPBANG, sst_pkg::M_OPGT, sst_pkg::M_OPLT: begin
               prim_valid = 1'b1;
               if (restart) begin
                  prim = sst_pkg::make_tok(sst_pkg::op_single(mode_ff), sst_pkg::E_NONE,
                                           line_f, start_f, FB'(1), 8'd0);
               end else begin
                  prim = sst_pkg::make_tok(sst_pkg::op_single(mode_ff) + 6'd1,
                                           sst_pkg::E_NONE, line_f, start_f, FB'(2), 8'd0);
               end
            end
            sst_pkg::M_OPAMP: begin
               prim_valid = 1'b1;
               if (source_byte == "&") begin
                  prim = sst_pkg::make_tok(sst_pkg::K_AND, sst_pkg::E_NONE, line_f, start_f,
                                           FB'(2), 8'd0);
               end else begin
                  prim = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_AMP, line_f, start_f,
                                           '0, "&");
               end
            end
            sst_pkg::M_OPBAR: begin
               prim_valid = 1'b1;
               if (source_byte == "|") begin
                  prim = sst_pkg::make_tok(sst_pkg::K_OR, sst_pkg::E_NONE, line_f, start_f,
                                           FB'(2), 8'd0);
               end else begin
                  prim = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_BAR, line_f, start_f,
                                           '0, "|");
               end
            end
            default: prim_valid = 1'b0;
         endcase
         sec_valid = restart && st.emit;
         if (st.fault) begin
            sec = sst_pkg::make_tok(sst_pkg::K_NUMBER, sst_pkg::E_CHAR, line_f, offset_f,
                                    '0, source_byte);
         end else begin
            sec = sst_pkg::make_tok(st.kind, sst_pkg::E_NONE, line_f, offset_f, FB'(1), 8'd0);
         end
      end
   end

   always_comb begin
      rec = '0;
      if (prim_valid) begin
         rec.first = prim;
         rec.second = sec;
         rec.two = sec_valid;
      end else begin
         rec.first = sec;
      end
      rec_push = take && (prim_valid || sec_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sst_pkg::M_IDLE;
         line_ff <= COUNTER_BITS'(1);
         offset_ff <= '0;
         start_ff <= '0;
         cand_ff <= '0;
         idlen_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         offset_ff <= offset_in;
         start_ff <= start_in;
         cand_ff <= cand_in;
         idlen_ff <= idlen_in;
      end
   end

endmodule

### rtl/sst_queue.sv
`timescale 1ns / 1ps
// short record queue between the lexer and the output stage
module sst_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sst_pkg::item_record_type push_rec,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output sst_pkg::item_record_type head_rec
);

   localparam int DEPTH = sst_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sst_pkg::item_record_type slots_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/sst_back.sv
`timescale 1ns / 1ps
// output stage: splits queued records into single token transfers
module sst_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  sst_pkg::item_record_type head_rec,
   output logic                     pop,
   sst_rsp_if.source                rsp_ch
);

   logic               out_valid_ff, out_valid_in;
   sst_pkg::token_type out_tok_ff, out_tok_in;
   logic               out_last_ff, out_last_in;
   logic               sel_ff, sel_in;
   logic               load;
   logic               cur_last;

   always_comb begin
      load = head_valid && (!out_valid_ff || rsp_ch.ready);
      cur_last = !head_rec.two || sel_ff;
      pop = load && cur_last;
      out_valid_in = out_valid_ff;
      out_tok_in = out_tok_ff;
      out_last_in = out_last_ff;
      sel_in = sel_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_tok_in = sel_ff ? head_rec.second : head_rec.first;
         out_last_in = cur_last;
         sel_in = !cur_last;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff <= out_tok_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sel_ff <= sel_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.token_kind = out_tok_ff.token_kind;
   assign rsp_ch.error_code = out_tok_ff.error_code;
   assign rsp_ch.line_number = out_tok_ff.line_number;
   assign rsp_ch.text_offset = out_tok_ff.text_offset;
   assign rsp_ch.text_length = out_tok_ff.text_length;
   assign rsp_ch.error_char = out_tok_ff.error_char;
   assign rsp_ch.last_of_item = out_last_ff;

endmodule

### rtl/sst_checker.sv
`timescale 1ns / 1ps
// port-level checks on the token channel, bound to the tokenizer top level
module sst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [5:0]                      rsp_token_kind,
   input logic [2:0]                      rsp_error_code,
   input logic [sst_pkg::FIELD_BITS-1:0]  rsp_text_length,
   input logic [7:0]                      rsp_error_char,
   input logic                            rsp_last_of_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("token dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token valid right after reset");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != sst_pkg::E_NONE) |->
         (rsp_token_kind == sst_pkg::K_NUMBER) && (rsp_text_length == '0))
      else $error("error result with token kind or length");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == sst_pkg::K_EOF) |->
         rsp_last_of_item && (rsp_error_code == sst_pkg::E_NONE))
      else $error("end of file not last of its item");

   a_amp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == sst_pkg::E_AMP) |-> (rsp_error_char == "&"))
      else $error("lone ampersand error with wrong character");

endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_token_kind  (rsp_ch.token_kind),
   .rsp_error_code  (rsp_ch.error_code),
   .rsp_text_length (rsp_ch.text_length),
   .rsp_error_char  (rsp_ch.error_char),
   .rsp_last_of_item(rsp_ch.last_of_item)
);

### tb/sst_token_checker.sv
`timescale 1ns / 1ps
// token predictor and scoreboard watching both channels of the source tokenizer
module sst_token_checker (
   input  logic        clock,
   input  logic        reset,
   sst_req_if          req_ch,
   sst_rsp_if          rsp_ch,
   output int unsigned fail_count,
   output int unsigned tokens_pending,
   output int unsigned tokens_checked
);

   localparam int CNT_BITS = sst_pkg::COUNTER_BITS_DEFAULT;
   localparam logic [31:0] CNT_TOP = 32'((64'd1 << CNT_BITS) - 64'd1);
   localparam logic [5:0] ERROR_KIND = sst_pkg::K_NUMBER;
   localparam int REPORT_LIMIT = 10;
   localparam int FB = sst_pkg::FIELD_BITS;

   typedef struct packed {
      sst_pkg::token_type tok;
      logic               last;
   } token_entry_type;

   string kw_words [sst_pkg::KW_COUNT] = '{
      "entier", "texte", "booleen", "liste", "si", "sinon", "tantque",
      "pour", "allant", "de", "a", "dans", "afficher", "fonction"
   };

   sst_pkg::lexer_mode_type      lex_mode;
   logic [31:0]                  line_no;
   logic [31:0]                  pos;
   logic [31:0]                  tok_begin;
   logic [sst_pkg::KW_COUNT-1:0] kw_mask;
   logic [3:0]                   word_len;
   token_entry_type              expected_tokens [$];
   token_entry_type              step_tokens [$];
   int unsigned                  mismatches = 0;
   int unsigned                  checked = 0;

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v >= CNT_TOP) ? CNT_TOP : v + 32'd1;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return (c == " ") || ((c >= 8'h09) && (c <= 8'h0d));
   endfunction

   function automatic string show(input token_entry_type t);
      return $sformatf("kind %0d err %0d line %0d off %0d len %0d char %0d last %0d",
                       t.tok.token_kind, t.tok.error_code, t.tok.line_number,
                       t.tok.text_offset, t.tok.text_length, t.tok.error_char, t.last);
   endfunction

   function automatic logic [5:0] pending_kind(input sst_pkg::lexer_mode_type m,
                                               input logic ext);
      case (m)
         sst_pkg::M_OPEQ: return ext ? sst_pkg::K_EQEQ : sst_pkg::K_EQ;
         sst_pkg::M_OPBANG: return ext ? sst_pkg::K_NE : sst_pkg::K_NOT;
         sst_pkg::M_OPGT: return ext ? sst_pkg::K_GE : sst_pkg::K_GT;
         default: return ext ? sst_pkg::K_LE : sst_pkg::K_LT;
      endcase
   endfunction

   function automatic logic [5:0] word_kind();
      for (int k = 0; k < sst_pkg::KW_COUNT; k++) begin
         if (kw_mask[k] && (kw_words[k].len() == int'(word_len))) begin
            return 6'(k + 1);
         end
      end
      return sst_pkg::K_IDENT;
   endfunction

   task automatic add_token(input logic [5:0] kind, input logic [2:0] err,
                            input logic [31:0] off, input logic [31:0] len,
                            input logic [7:0] ch);
      token_entry_type e;
      e.tok.token_kind = kind;
      e.tok.error_code = err;
      e.tok.line_number = line_no[FB-1:0];
      e.tok.text_offset = off[FB-1:0];
      e.tok.text_length = len[FB-1:0];
      e.tok.error_char = ch;
      e.last = 1'b0;
      step_tokens.insert(step_tokens.size(), e);
   endtask

   task automatic reset_lexer();
      lex_mode = sst_pkg::M_IDLE;
      line_no = 32'd1;
      pos = '0;
      tok_begin = '0;
      kw_mask = '0;
      word_len = '0;
   endtask

   task automatic grow_word(input logic [7:0] c);
      logic [sst_pkg::KW_COUNT-1:0] m;
      m = '0;
      for (int k = 0; k < sst_pkg::KW_COUNT; k++) begin
         if (((word_len == 4'd0) || kw_mask[k]) && (int'(word_len) < kw_words[k].len()) &&
             (8'(kw_words[k][int'(word_len)]) == c)) begin
            m[k] = 1'b1;
         end
      end
      kw_mask = m;
      if (word_len != sst_pkg::IDENT_LEN_MAX) word_len = word_len + 4'd1;
   endtask

   task automatic open_token(input logic [7:0] c, input logic [31:0] off);
      lex_mode = sst_pkg::M_IDLE;
      tok_begin = off;
      if (blank_char(c)) begin
      end else if (digit_char(c)) begin
         lex_mode = sst_pkg::M_NUMBER;
      end else if (letter_char(c) || (c == sst_pkg::CH_UNDERSCORE)) begin
         lex_mode = sst_pkg::M_IDENT;
         word_len = '0;
         kw_mask = '0;
         grow_word(c);
      end else begin
         case (c)
            "\"": begin
               lex_mode = sst_pkg::M_STRING;
               tok_begin = bump(off);
            end
            "/": lex_mode = sst_pkg::M_SLASH;
            "=": lex_mode = sst_pkg::M_OPEQ;
            "!": lex_mode = sst_pkg::M_OPBANG;
            ">": lex_mode = sst_pkg::M_OPGT;
            "<": lex_mode = sst_pkg::M_OPLT;
            "&": lex_mode = sst_pkg::M_OPAMP;
            "|": lex_mode = sst_pkg::M_OPBAR;
            "+": add_token(sst_pkg::K_PLUS, sst_pkg::E_NONE, off, 1, 8'd0);
            "-": add_token(sst_pkg::K_MINUS, sst_pkg::E_NONE, off, 1, 8'd0);
            "*": add_token(sst_pkg::K_STAR, sst_pkg::E_NONE, off, 1, 8'd0);
            "%": add_token(sst_pkg::K_PERCENT, sst_pkg::E_NONE, off, 1, 8'd0);
            ";": add_token(sst_pkg::K_SEMI, sst_pkg::E_NONE, off, 1, 8'd0);
            "(": add_token(sst_pkg::K_LPAREN, sst_pkg::E_NONE, off, 1, 8'd0);
            ")": add_token(sst_pkg::K_RPAREN, sst_pkg::E_NONE, off, 1, 8'd0);
            "{": add_token(sst_pkg::K_LBRACE, sst_pkg::E_NONE, off, 1, 8'd0);
            "}": add_token(sst_pkg::K_RBRACE, sst_pkg::E_NONE, off, 1, 8'd0);
            "[": add_token(sst_pkg::K_LBRACKET, sst_pkg::E_NONE, off, 1, 8'd0);
            "]": add_token(sst_pkg::K_RBRACKET, sst_pkg::E_NONE, off, 1, 8'd0);
            ",": add_token(sst_pkg::K_COMMA, sst_pkg::E_NONE, off, 1, 8'd0);
            default: begin
               add_token(ERROR_KIND, sst_pkg::E_CHAR, off, 0, c);
               lex_mode = sst_pkg::M_ERROR;
            end
         endcase
      end
   endtask

   task automatic lex_source_byte(input logic [7:0] c);
      logic [31:0] off;
      off = pos;
      if (lex_mode != sst_pkg::M_ERROR) begin
         case (lex_mode)
            sst_pkg::M_IDLE: open_token(c, off);
            sst_pkg::M_SLASH: begin
               if (c == "/") begin
                  lex_mode = sst_pkg::M_LINEC;
               end else if (c == "*") begin
                  lex_mode = sst_pkg::M_BLOCKC;
               end else begin
                  add_token(sst_pkg::K_SLASH, sst_pkg::E_NONE, tok_begin, 1, 8'd0);
                  open_token(c, off);
               end
            end
            sst_pkg::M_LINEC: begin
               if (c == sst_pkg::CH_NEWLINE) lex_mode = sst_pkg::M_IDLE;
            end
            sst_pkg::M_BLOCKC: begin
               if (c == "*") lex_mode = sst_pkg::M_BLOCKSTAR;
            end
            sst_pkg::M_BLOCKSTAR: begin
               if (c == "/") begin
                  lex_mode = sst_pkg::M_IDLE;
               end else if (c != "*") begin
                  lex_mode = sst_pkg::M_BLOCKC;
               end
            end
            sst_pkg::M_NUMBER: begin
               if (!digit_char(c)) begin
                  add_token(sst_pkg::K_NUMBER, sst_pkg::E_NONE, tok_begin, off - tok_begin,
                            8'd0);
                  open_token(c, off);
               end
            end
            sst_pkg::M_IDENT: begin
               if (letter_char(c) || digit_char(c) || (c == sst_pkg::CH_UNDERSCORE)) begin
                  grow_word(c);
               end else begin
                  add_token(word_kind(), sst_pkg::E_NONE, tok_begin, off - tok_begin, 8'd0);
                  open_token(c, off);
               end
            end
            sst_pkg::M_STRING: begin
               if (c == "\"") begin
                  add_token(sst_pkg::K_STRING, sst_pkg::E_NONE, tok_begin,
                            (off >= tok_begin) ? off - tok_begin : 32'd0, 8'd0);
                  lex_mode = sst_pkg::M_IDLE;
               end
            end
            sst_pkg::M_OPEQ, sst_pkg::M_OPBANG, sst_pkg::M_OPGT, sst_pkg::M_OPLT: begin
               if (c == "=") begin
                  add_token(pending_kind(lex_mode, 1'b1), sst_pkg::E_NONE, tok_begin, 2,
                            8'd0);
                  lex_mode = sst_pkg::M_IDLE;
               end else begin
                  add_token(pending_kind(lex_mode, 1'b0), sst_pkg::E_NONE, tok_begin, 1,
                            8'd0);
                  open_token(c, off);
               end
            end
            sst_pkg::M_OPAMP: begin
               if (c == "&") begin
                  add_token(sst_pkg::K_AND, sst_pkg::E_NONE, tok_begin, 2, 8'd0);
                  lex_mode = sst_pkg::M_IDLE;
               end else begin
                  add_token(ERROR_KIND, sst_pkg::E_AMP, tok_begin, 0, "&");
                  lex_mode = sst_pkg::M_ERROR;
               end
            end
            sst_pkg::M_OPBAR: begin
               if (c == "|") begin
                  add_token(sst_pkg::K_OR, sst_pkg::E_NONE, tok_begin, 2, 8'd0);
                  lex_mode = sst_pkg::M_IDLE;
               end else begin
                  add_token(ERROR_KIND, sst_pkg::E_BAR, tok_begin, 0, "|");
                  lex_mode = sst_pkg::M_ERROR;
               end
            end
            default: lex_mode = sst_pkg::M_ERROR;
         endcase
         if (c == sst_pkg::CH_NEWLINE) line_no = bump(line_no);
         pos = bump(pos);
      end
   endtask

   task automatic lex_end_of_source();
      logic [31:0] len;
      logic        with_eof;
      len = pos - tok_begin;
      with_eof = 1'b1;
      case (lex_mode)
         sst_pkg::M_SLASH: add_token(sst_pkg::K_SLASH, sst_pkg::E_NONE, tok_begin, 1, 8'd0);
         sst_pkg::M_NUMBER: add_token(sst_pkg::K_NUMBER, sst_pkg::E_NONE, tok_begin, len, 8'd0);
         sst_pkg::M_IDENT: add_token(word_kind(), sst_pkg::E_NONE, tok_begin, len, 8'd0);
         sst_pkg::M_STRING: begin
            add_token(ERROR_KIND, sst_pkg::E_STRING, tok_begin, 0, 8'd0);
            with_eof = 1'b0;
         end
         sst_pkg::M_OPEQ, sst_pkg::M_OPBANG, sst_pkg::M_OPGT, sst_pkg::M_OPLT: begin
            add_token(pending_kind(lex_mode, 1'b0), sst_pkg::E_NONE, tok_begin, 1, 8'd0);
         end
         sst_pkg::M_OPAMP: begin
            add_token(ERROR_KIND, sst_pkg::E_AMP, tok_begin, 0, "&");
            with_eof = 1'b0;
         end
         sst_pkg::M_OPBAR: begin
            add_token(ERROR_KIND, sst_pkg::E_BAR, tok_begin, 0, "|");
            with_eof = 1'b0;
         end
         sst_pkg::M_ERROR: with_eof = 1'b0;
         default: ;
      endcase
      if (with_eof) add_token(sst_pkg::K_EOF, sst_pkg::E_NONE, pos, 0, 8'd0);
      reset_lexer();
   endtask

   always @(posedge clock) begin : scoreboard
      token_entry_type got;
      token_entry_type want;
      if (reset) begin
         reset_lexer();
         expected_tokens.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            step_tokens.delete();
            if (req_ch.cmd == sst_pkg::CMD_END) begin
               lex_end_of_source();
            end else begin
               lex_source_byte(req_ch.source_byte);
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
            foreach (step_tokens[i]) begin
               expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.tok.token_kind = rsp_ch.token_kind;
            got.tok.error_code = rsp_ch.error_code;
            got.tok.line_number = rsp_ch.line_number;
            got.tok.text_offset = rsp_ch.text_offset;
            got.tok.text_length = rsp_ch.text_length;
            got.tok.error_char = rsp_ch.error_char;
            got.last = rsp_ch.last_of_item;
            checked++;
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t unexpected token: expected none, actual %s", $realtime,
                           show(got));
               end
            end else begin
               want = expected_tokens.pop_front();
               if ((got.tok.token_kind !== want.tok.token_kind) ||
                   (got.tok.error_code !== want.tok.error_code) ||
                   (got.tok.line_number !== want.tok.line_number) ||
                   (got.tok.text_offset !== want.tok.text_offset) ||
                   (got.tok.text_length !== want.tok.text_length) ||
                   (got.tok.error_char !== want.tok.error_char) ||
                   (got.last !== want.last)) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t token mismatch: expected %s", $realtime, show(want));
                     $display("%0t                 actual   %s", $realtime, show(got));
                  end
               end
            end
         end
      end
      fail_count <= mismatches;
      tokens_pending <= expected_tokens.size();
      tokens_checked <= checked;
   end

endmodule

### tb/tb_script_source_tokenizer.sv
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the source tokenizer
module tb_script_source_tokenizer;

   localparam int SOURCE_ITEMS = 1300;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_WAIT = 18;
   localparam int OP_COUNT = 23;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned tokens_pending;
   int unsigned tokens_checked;
   int unsigned items_sent = 0;
   int unsigned streams_sent = 0;
   int unsigned idle_cycles = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   logic [7:0]  text_bytes [$];

   string kw_words [sst_pkg::KW_COUNT] = '{
      "entier", "texte", "booleen", "liste", "si", "sinon", "tantque",
      "pour", "allant", "de", "a", "dans", "afficher", "fonction"
   };
   string op_words [OP_COUNT] = '{
      "+", "-", "*", "/", "%", "=", "==", "!", "!=", ">", ">=", "<", "<=",
      "&&", "||", ";", "(", ")", "{", "}", "[", "]", ","
   };

   sst_req_if req_ch ();
   sst_rsp_if rsp_ch ();

   script_source_tokenizer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sst_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending),
      .tokens_checked (tokens_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_wait(input bit calm);
      if (calm || ($urandom_range(0, 2) != 0)) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic logic [7:0] blank_byte();
      int r;
      r = $urandom_range(0, 5);
      return (r == 0) ? 8'h20 : 8'(8 + r);
   endfunction

   function automatic logic [7:0] lead_byte();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return sst_pkg::CH_UNDERSCORE;
   endfunction

   function automatic logic [7:0] word_byte();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return sst_pkg::CH_UNDERSCORE;
   endfunction

   task automatic send_item(input logic cmd, input logic [7:0] b);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.source_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_end();
      send_item(sst_pkg::CMD_END, 8'($urandom_range(0, 255)));
      streams_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(sst_pkg::CMD_BYTE, 8'(s[i]));
   endtask

   task automatic drain_tokens();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tokens_pending != 0);
   endtask

   task automatic put_byte(input logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(8'(s[i]));
   endtask

   task automatic add_word();
      string w;
      int    n;
      w = kw_words[$urandom_range(0, sst_pkg::KW_COUNT - 1)];
      case ($urandom_range(0, 3))
         0: push_string(w);
         1: push_string(w.substr(0, $urandom_range(0, w.len() - 1)));
         2: begin
            push_string(w);
            repeat ($urandom_range(1, 3)) put_byte(word_byte());
         end
         default: begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
            put_byte(lead_byte());
            repeat (n - 1) put_byte(word_byte());
         end
      endcase
   endtask

   task automatic add_string(input bit closed);
      logic [7:0] b;
      put_byte("\"");
      repeat ($urandom_range(0, 8)) begin
         do b = 8'($urandom_range(0, 255)); while (b == "\"");
         put_byte(b);
      end
      if (closed) put_byte("\"");
   endtask

   task automatic add_comment(output bit open_end);
      logic [7:0] b;
      open_end = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 1) == 1) begin
         push_string("//");
         repeat ($urandom_range(0, 8)) begin
            do b = 8'($urandom_range(0, 255)); while (b == sst_pkg::CH_NEWLINE);
            put_byte(b);
         end
         if (!open_end) put_byte(sst_pkg::CH_NEWLINE);
      end else begin
         push_string("/*");
         repeat ($urandom_range(0, 8)) begin
            b = ($urandom_range(0, 3) == 0) ? 8'("*") : 8'($urandom_range(0, 255));
            put_byte(b);
         end
         if (!open_end) begin
            if ($urandom_range(0, 1) == 1) put_byte("*");
            push_string("*/");
         end
      end
   endtask

   task automatic add_broken();
      logic [7:0] b;
      case ($urandom_range(0, 4))
         0: begin
            put_byte("&");
            do b = 8'($urandom_range(0, 255)); while (b == "&");
            put_byte(b);
         end
         1: begin
            put_byte("|");
            do b = 8'($urandom_range(0, 255)); while (b == "|");
            put_byte(b);
         end
         2: add_string(1'b0);
         3: put_byte("&");
         default: put_byte("|");
      endcase
   endtask

   task automatic send_random_stream();
      int target;
      int pick;
      bit stop;
      text_bytes.delete();
      stop = 1'b0;
      target = $urandom_range(4, 40);
      while ((text_bytes.size() < target) && !stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            add_word();
         end else if (pick < 32) begin
            repeat ($urandom_range(1, 6)) put_byte(8'("0" + $urandom_range(0, 9)));
         end else if (pick < 42) begin
            add_string(1'b1);
         end else if (pick < 72) begin
            push_string(op_words[$urandom_range(0, OP_COUNT - 1)]);
         end else if (pick < 80) begin
            put_byte(blank_byte());
         end else if (pick < 90) begin
            add_comment(stop);
         end else if (pick < 95) begin
            add_broken();
            stop = 1'b1;
         end else begin
            put_byte(8'($urandom_range(0, 255)));
            stop = 1'b1;
         end
         if (!stop && ($urandom_range(0, 9) < 7)) put_byte(blank_byte());
      end
      foreach (text_bytes[i]) send_item(sst_pkg::CMD_BYTE, text_bytes[i]);
      send_end();
   endtask

   initial begin : token_sink
      int          stall;
      int unsigned taken;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
         if ((taken % 48) == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : source_feed
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= sst_pkg::CMD_BYTE;
      req_ch.source_byte <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // keyword ended by a two-character operator, number, trailing slash
      send_text("si<=9/");
      send_end();
      // unclosed string, unclosed block comment
      send_text("\"ab");
      send_end();
      send_text("/*");
      send_end();
      // lone ampersand, then ignored bytes; lone bar at the end item
      send_text("&xy");
      send_end();
      send_text("|");
      send_end();
      // unexpected bytes at both extremes
      send_item(sst_pkg::CMD_BYTE, 8'hff);
      send_end();
      send_item(sst_pkg::CMD_BYTE, 8'h00);
      send_end();
      drain_tokens();

      while (items_sent < SOURCE_ITEMS) begin
         if ($urandom_range(0, 7) == 0) drain_tokens();
         req_calm = ($urandom_range(0, 4) == 0);
         send_random_stream();
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tokens_pending != 0);
      repeat (20) @(posedge clock);

      $display("run covered %0d source items in %0d streams, %0d tokens checked",
               items_sent, streams_sent, tokens_checked);
      if ((fail_count == 0) && (tokens_pending == 0)) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
